// ----- src/pal_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list package
// Sizes, request and status codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 7;

  localparam int IN_W     = ((POS_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_RAW  = DATA_W + STAT_W + OCNT_W + 1;
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET    = 3'd0,
    KIND_SET    = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GET_WAIT,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_IDX_M1,
    RD_IDX
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_POS_VAL,
    WR_IDX_RD,
    WR_IDX_M1_RD
  } wr_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT,
    IDX_POS_P1,
    IDX_DEC,
    IDX_INC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef struct packed {
    logic      load_item;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    idx_op_t   idx_op;
    cnt_op_t   cnt_op;
    logic      set_status;
    status_e_t status_code;
    logic      use_rd;
    logic      out_load;
  } pal_cmd_t;

  typedef struct packed {
    kind_e_t kind;
    logic    pos_below_cnt;
    logic    pos_upto_cnt;
    logic    full;
    logic    idx_above_pos;
    logic    idx_below_cnt;
    logic    out_free;
  } pal_stat_t;

endpackage
`default_nettype wire

// ----- src/pal_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list datapath
// Element memory, element count, item and result registers, and the
// address and compare logic driven by the controller commands.
// ----------------------------------------------------------------------------
module pal_datapath import pal_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic [DATA_W-1:0]  cfg_data,
  input  wire logic [KIND_W-1:0]  s_tuser,
  input  wire logic [IN_W-1:0]    s_tdata,
  output      logic               m_tvalid,
  input  wire logic               m_tready,
  output      logic [OUT_W-1:0]   m_tdata,
  input  wire pal_cmd_t           cmd,
  output      pal_stat_t          stat
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] empty_value;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] val;
  status_e_t         status;
  logic              use_rd;

  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  idx_ext;
  logic [CNT_W-1:0]  idx_m1;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [CNT_W-1:0]  idx_next;
  logic [CNT_W-1:0]  count_next;
  logic [OCNT_W-1:0] out_count;
  logic [DATA_W-1:0] out_value;

  assign pos_ext = CMP_W'(pos);
  assign cnt_ext = CMP_W'(count);
  assign idx_ext = CMP_W'(idx);
  assign idx_m1  = idx - CNT_W'(1);

  always_comb begin
    stat.kind          = kind_e_t'(kind);
    stat.pos_below_cnt = pos_ext < cnt_ext;
    stat.pos_upto_cnt  = pos_ext <= cnt_ext;
    stat.full          = count == CNT_W'(CAPACITY);
    stat.idx_above_pos = idx_ext > pos_ext;
    stat.idx_below_cnt = idx < count;
    stat.out_free      = !m_tvalid || m_tready;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_POS:    rd_addr = pos_ext[ADDR_W-1:0];
      RD_IDX_M1: rd_addr = idx_m1[ADDR_W-1:0];
      RD_IDX:    rd_addr = idx[ADDR_W-1:0];
      default:   rd_addr = idx[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_POS_VAL: begin
        wr_addr = pos_ext[ADDR_W-1:0];
        wr_data = val;
      end
      WR_IDX_RD: begin
        wr_addr = idx[ADDR_W-1:0];
        wr_data = rd_data;
      end
      WR_IDX_M1_RD: begin
        wr_addr = idx_m1[ADDR_W-1:0];
        wr_data = rd_data;
      end
      default: begin
        wr_addr = idx[ADDR_W-1:0];
        wr_data = rd_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_HOLD:   idx_next = idx;
      IDX_CNT:    idx_next = count;
      IDX_POS_P1: idx_next = CNT_W'(pos_ext + CMP_W'(1));
      IDX_DEC:    idx_next = idx_m1;
      IDX_INC:    idx_next = idx + CNT_W'(1);
      default:    idx_next = idx;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_HOLD: count_next = count;
      CNT_INC:  count_next = count + CNT_W'(1);
      CNT_DEC:  count_next = count - CNT_W'(1);
      CNT_CLR:  count_next = '0;
      default:  count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.load_item) begin
      kind <= s_tuser;
      pos  <= s_tdata[POS_W-1:0];
      val  <= s_tdata[POS_W+DATA_W-1:POS_W];
    end
    if (cmd.set_status) begin
      status <= cmd.status_code;
      use_rd <= cmd.use_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      empty_value <= '0;
    end else begin
      count <= count_next;
      if (cfg_valid) begin
        empty_value <= cfg_data;
      end
    end
  end

  assign out_count = cnt_ext[OCNT_W-1:0];
  assign out_value = use_rd ? rd_data : empty_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {(OUT_W - OUT_RAW)'(0), count == '0, out_count, status, out_value};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + CNT_W'(1)) || (count == $past(count) - CNT_W'(1)) ||
      (count == '0))
    else $error("element count moved by more than one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a held item");

  a_read_in_list: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.rd_sel == RD_POS) |-> stat.pos_below_cnt)
    else $error("get read outside the list");

endmodule
`default_nettype wire

// ----- src/pal_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list controller
// Sequences one request: decode, memory read, element shifting with one
// memory read and one write per entry, and the hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module pal_ctrl import pal_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output      logic      s_tready,
  input  wire pal_stat_t stat,
  output      pal_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_GET:    state_next = stat.pos_below_cnt ? S_GET_WAIT : S_FINISH;
          KIND_INSERT: begin
            if (stat.pos_upto_cnt && !stat.full) state_next = S_INS_RD;
            else state_next = S_FINISH;
          end
          KIND_REMOVE: state_next = stat.pos_below_cnt ? S_REM_RD : S_FINISH;
          default:     state_next = S_FINISH;
        endcase
      end
      S_GET_WAIT: state_next = S_FINISH;
      S_INS_RD:   state_next = stat.idx_above_pos ? S_INS_WR : S_FINISH;
      S_INS_WR:   state_next = S_INS_RD;
      S_REM_RD:   state_next = stat.idx_below_cnt ? S_REM_WR : S_FINISH;
      S_REM_WR:   state_next = S_REM_RD;
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = 1'b0;
    cmd.load_item   = 1'b0;
    cmd.rd_en       = 1'b0;
    cmd.rd_sel      = RD_POS;
    cmd.wr_en       = 1'b0;
    cmd.wr_sel      = WR_POS_VAL;
    cmd.idx_op      = IDX_HOLD;
    cmd.cnt_op      = CNT_HOLD;
    cmd.set_status  = 1'b0;
    cmd.status_code = ST_DONE;
    cmd.use_rd      = 1'b0;
    cmd.out_load    = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_item = s_tvalid;
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        case (stat.kind)
          KIND_GET: begin
            if (stat.pos_below_cnt) begin
              cmd.rd_en  = 1'b1;
              cmd.use_rd = 1'b1;
            end else begin
              cmd.status_code = ST_RANGE;
            end
          end
          KIND_SET: begin
            if (stat.pos_below_cnt) cmd.wr_en = 1'b1;
            else cmd.status_code = ST_RANGE;
          end
          KIND_INSERT: begin
            if (!stat.pos_upto_cnt) cmd.status_code = ST_RANGE;
            else if (stat.full) cmd.status_code = ST_FULL;
            else cmd.idx_op = IDX_CNT;
          end
          KIND_REMOVE: begin
            if (stat.pos_below_cnt) cmd.idx_op = IDX_POS_P1;
            else cmd.status_code = ST_RANGE;
          end
          KIND_CLEAR: cmd.cnt_op = CNT_CLR;
          default: cmd.status_code = ST_DONE;
        endcase
      end
      S_INS_RD: begin
        if (stat.idx_above_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_POS_VAL;
          cmd.cnt_op = CNT_INC;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_IDX_RD;
        cmd.idx_op = IDX_DEC;
      end
      S_REM_RD: begin
        if (stat.idx_below_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
        end else begin
          cmd.cnt_op = CNT_DEC;
        end
      end
      S_REM_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_IDX_M1_RD;
        cmd.idx_op = IDX_INC;
      end
      S_FINISH: cmd.out_load = stat.out_free;
      default: cmd.out_load = 1'b0;
    endcase
  end

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_en && cmd.wr_en))
    else $error("memory read and write in the same cycle");

  a_shift_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR || state == S_REM_WR) |-> $past(cmd.rd_en))
    else $error("shift write without a preceding read");

endmodule
`default_nettype wire

// ----- src/positional_array_list.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list
// Ordered list of signed 32-bit elements with get, set, insert, remove and
// clear requests, each answered with one result item.
// ----------------------------------------------------------------------------
// Each request is decoded, then get reads its element, insert shifts the
// elements from count down to position up before writing the new one, and
// remove shifts the elements above position down; each moved element costs
// one memory read and one write on the single element RAM port pair.
// One item in work at a time; the next item is taken in the cycle after the
// result is loaded. Reset empties the list and clears empty_value to 0.
module positional_array_list import pal_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic [DATA_W-1:0] cfg_data,    // empty_value
  input  wire logic              s_tvalid,
  output      logic              s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,     // position[6:0], value[38:7]
  input  wire logic [KIND_W-1:0] s_tuser,     // kind[2:0]
  output      logic              m_tvalid,
  input  wire logic              m_tready,
  output      logic [OUT_W-1:0]  m_tdata      // read_value[31:0], status[33:32],
                                              // count[40:34], is_empty[41]
);

  pal_cmd_t  cmd;
  pal_stat_t stat;

  assign cfg_ready = 1'b1;

  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pal_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire
